@@ rtl/mgmt_pkg.sv @@
// shared types and constants for the multicast group membership table
package mgmt_pkg;

    localparam int unsigned IFACE_W     = 3;
    localparam int unsigned GROUP_W     = 32;
    localparam int unsigned MODE_W      = 3;
    localparam int unsigned MASK_W      = 8;
    localparam int unsigned QI_W        = 16;
    localparam int unsigned NUM_IFACES  = 8;
    localparam logic [MODE_W-1:0] LEAVE_RECORD = 3'd3;
    localparam logic [QI_W-1:0]   QUERY_INTERVAL_RST = 16'd125;

    typedef enum logic [1:0] {
        REQ_RECORD = 2'd0,
        REQ_PACKET = 2'd1,
        REQ_TICK   = 2'd2
    } req_t;

    // item walking down the cell chain
    typedef struct packed {
        logic               vld;
        logic               is_rec;
        logic [IFACE_W-1:0] iface;
        logic [GROUP_W-1:0] group;
        logic [MODE_W-1:0]  mode;
        logic               found;
        logic               placed;
        logic [MASK_W-1:0]  mask;
    } tok_t;

endpackage

@@ rtl/mgmt_cell.sv @@
// one table entry with its compare logic and a chain stage for the walking item
module mgmt_cell
    import mgmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  tok_t tok_in,
    output tok_t tok_out
);

    logic               valid_reg;
    logic [IFACE_W-1:0] iface_reg;
    logic [GROUP_W-1:0] group_reg;
    logic [MODE_W-1:0]  mode_reg;
    tok_t               tok_reg;
    tok_t               tok_next;
    logic               hit;
    logic               rec_hit;
    logic               take;

    assign hit     = tok_in.vld && valid_reg && (group_reg == tok_in.group);
    assign rec_hit = hit && tok_in.is_rec && (iface_reg == tok_in.iface);
    // free slots always follow the used ones, so the first free cell is the lowest
    assign take    = tok_in.vld && tok_in.is_rec && !valid_reg
                     && !tok_in.found && !tok_in.placed;

    always_comb
    begin
        tok_next = tok_in;
        if (rec_hit)
        begin
            tok_next.found = 1'b1;
        end
        if (hit && !tok_in.is_rec)
        begin
            tok_next.mask = tok_in.mask | (MASK_W'(1) << iface_reg);
        end
        if (take)
        begin
            tok_next.placed = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            if (take)
            begin
                valid_reg <= 1'b1;
            end
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            iface_reg <= tok_in.iface;
            group_reg <= tok_in.group;
        end
        if (take || rec_hit)
        begin
            mode_reg <= tok_in.mode;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ rtl/multicast_group_membership_table.sv @@
// top level of the multicast group membership table: cell chain, tick counter, result register
// A membership record or a data packet walks down a chain of TABLE_DEPTH entry cells, one
// cell per cycle; its result then passes from the last cell into the result register and on
// into the output register, and the next item can be accepted once that load is done; the
// chain length sets how long such an item occupies the block. A tick item or an item that
// needs no lookup skips the walk and goes straight to the output load. A result stalled on
// the output adds its stall to the item after it. One item is in work at a time; a new item
// is accepted while the previous result still waits on the output register. Records fill
// entries lowest first and entries are never removed, so a record that finds no match
// takes the first free cell it meets; table_full is raised when the walk ends with no match
// and no free cell. A leave record (type 3) raises group_query even when dropped. Records
// on interfaces at or above 8 are ignored and give an all-zero result. No clearing pass is
// needed after reset.
module multicast_group_membership_table
    import mgmt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    // config: query interval in ticks
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // request items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // interface_req[2:0], group_address[34:3], rec_mode[37:35]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // forward_mask[7:0]
    output logic [2:0]  m_axis_tuser    // general_query[0], group_query[1], table_full[2]
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t             state_reg;
    state_t             state_next;

    logic [QI_W-1:0]    query_interval_reg;
    logic [QI_W-1:0]    tick_count_reg;
    logic [QI_W-1:0]    tick_inc;

    // pending result
    logic [MASK_W-1:0]  res_mask_reg;
    logic               res_gen_reg;
    logic               res_gq_reg;
    logic               res_full_reg;

    // output register
    logic               out_vld_reg;
    logic [MASK_W-1:0]  out_mask_reg;
    logic [2:0]         out_flags_reg;

    // request fields
    logic [IFACE_W-1:0] in_iface;
    logic [GROUP_W-1:0] in_group;
    logic [MODE_W-1:0]  in_mode;
    logic               in_acc;
    logic               rec_ok;
    logic               launch;

    tok_t               chain [TABLE_DEPTH+1];
    tok_t               tail;

    assign in_iface = s_axis_tdata[2:0];
    assign in_group = s_axis_tdata[34:3];
    assign in_mode  = s_axis_tdata[37:35];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign rec_ok        = (32'(in_iface) < NUM_IFACES);

    // records on a known interface and data packets walk the chain
    always_comb
    begin
        launch = 1'b0;
        case (req_t'(s_axis_tuser))
            REQ_RECORD: launch = in_acc && rec_ok;
            REQ_PACKET: launch = in_acc;
            default:    launch = 1'b0;
        endcase
    end

    always_comb
    begin
        chain[0].vld    = launch;
        chain[0].is_rec = (s_axis_tuser == REQ_RECORD);
        chain[0].iface  = in_iface;
        chain[0].group  = in_group;
        chain[0].mode   = in_mode;
        chain[0].found  = 1'b0;
        chain[0].placed = 1'b0;
        chain[0].mask   = '0;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        mgmt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    assign tail     = chain[TABLE_DEPTH];
    assign tick_inc = tick_count_reg + QI_W'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = launch ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK:
            begin
                if (tail.vld)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            query_interval_reg <= QUERY_INTERVAL_RST;
            tick_count_reg     <= '0;
            out_vld_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                query_interval_reg <= cfg_wdata;
            end
            // tick counter wraps at 2^16, cleared when it meets the interval
            if (in_acc && (s_axis_tuser == REQ_TICK))
            begin
                tick_count_reg <= (tick_inc == query_interval_reg) ? '0 : tick_inc;
            end
            if (state_reg == ST_DONE && (!out_vld_reg || m_axis_tready))
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            res_mask_reg <= '0;
            res_full_reg <= 1'b0;
            res_gen_reg  <= (s_axis_tuser == REQ_TICK) && (tick_inc == query_interval_reg);
            res_gq_reg   <= (s_axis_tuser == REQ_RECORD) && rec_ok && (in_mode == LEAVE_RECORD);
        end
        else if (state_reg == ST_WALK && tail.vld)
        begin
            res_mask_reg <= tail.mask;
            res_full_reg <= tail.is_rec && !tail.found && !tail.placed;
        end
        if (state_reg == ST_DONE && (!out_vld_reg || m_axis_tready))
        begin
            out_mask_reg  <= res_mask_reg;
            out_flags_reg <= {res_full_reg, res_gq_reg, res_gen_reg};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_mask_reg;
    assign m_axis_tuser  = out_flags_reg;

endmodule

@@ rtl/mgmt_checker.sv @@
// port-level checks for the multicast group membership table, bound to the top level
module mgmt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while another is in work");

    // a tick result never carries record flags
    a_flags_apart: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && (m_axis_tuser[1] || m_axis_tuser[2])))
        else $error("general query mixed with record flags");

    // a forward mask only comes from a data packet
    a_mask_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata != 8'd0) |-> (m_axis_tuser == 3'd0))
        else $error("forward mask with flags set");

endmodule

bind multicast_group_membership_table mgmt_checker u_mgmt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ bench/membership_table_watch.sv @@
// result checker for the multicast group membership table: predicts each result item and compares
module membership_table_watch
    import mgmt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [MASK_W-1:0] forward_mask;
        logic              general_query;
        logic              group_query;
        logic              table_full;
    } lookup_result_t;

    // shadow membership table and query timer
    logic               entry_used  [TABLE_DEPTH];
    logic [IFACE_W-1:0] entry_port  [TABLE_DEPTH];
    logic [GROUP_W-1:0] entry_group [TABLE_DEPTH];
    logic [MODE_W-1:0]  entry_mode  [TABLE_DEPTH];
    logic [QI_W-1:0]    tick_total;
    logic [QI_W-1:0]    query_period;

    lookup_result_t awaited_results [$];
    int mismatch_count = 0;
    int pending_count  = 0;

    assign mismatches  = mismatch_count;
    assign outstanding = pending_count;

    task automatic report_mismatch(input string field_name, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_count < 40)
            $display("%0t ns: mismatch on %s, got %0h, expected %0h",
                     $realtime, field_name, got, want);
        mismatch_count++;
    endtask

    // updates the shadow table and timer for one request, returns its result item
    function automatic lookup_result_t apply_request(input logic [1:0] kind,
                                                     input logic [IFACE_W-1:0] ifc,
                                                     input logic [GROUP_W-1:0] grp,
                                                     input logic [MODE_W-1:0] mode);
        lookup_result_t res;
        logic hit;
        int spare;
        res   = '0;
        hit   = 1'b0;
        spare = -1;
        if (kind == REQ_RECORD)
        begin
            if (ifc < NUM_IFACES)
            begin
                if (mode == LEAVE_RECORD)
                    res.group_query = 1'b1;
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (entry_used[i])
                    begin
                        if (entry_port[i] == ifc && entry_group[i] == grp)
                        begin
                            entry_mode[i] = mode;
                            hit = 1'b1;
                        end
                    end
                    else if (spare < 0)
                        spare = i;
                end
                if (!hit && spare < 0)
                    res.table_full = 1'b1;
                else if (!hit)
                begin
                    entry_used[spare]  = 1'b1;
                    entry_port[spare]  = ifc;
                    entry_group[spare] = grp;
                    entry_mode[spare]  = mode;
                end
            end
        end
        else if (kind == REQ_PACKET)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (entry_used[i] && entry_group[i] == grp && entry_port[i] < MASK_W)
                    res.forward_mask[entry_port[i]] = 1'b1;
        end
        else if (kind == REQ_TICK)
        begin
            tick_total = tick_total + 1'b1;
            if (tick_total == query_period)
            begin
                res.general_query = 1'b1;
                tick_total = '0;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t expected_res;
        lookup_result_t next_res;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                entry_used[i] = 1'b0;
            tick_total   = '0;
            query_period = QUERY_INTERVAL_RST;
            awaited_results.delete();
        end
        else
        begin
            if (cfg_we)
                query_period = cfg_wdata;
            // results leave before a new request enters, so compare first
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result item with nothing pending",
                                    {m_axis_tuser, m_axis_tdata}, 0);
                else
                begin
                    expected_res = awaited_results.pop_front();
                    if (m_axis_tdata !== expected_res.forward_mask)
                        report_mismatch("forward_mask", m_axis_tdata,
                                        expected_res.forward_mask);
                    if (m_axis_tuser[0] !== expected_res.general_query)
                        report_mismatch("general_query", m_axis_tuser[0],
                                        expected_res.general_query);
                    if (m_axis_tuser[1] !== expected_res.group_query)
                        report_mismatch("group_query", m_axis_tuser[1],
                                        expected_res.group_query);
                    if (m_axis_tuser[2] !== expected_res.table_full)
                        report_mismatch("table_full", m_axis_tuser[2],
                                        expected_res.table_full);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                next_res = apply_request(s_axis_tuser, s_axis_tdata[2:0],
                                         s_axis_tdata[34:3], s_axis_tdata[37:35]);
                awaited_results = {awaited_results, next_res};
            end
        end
        pending_count = awaited_results.size();
    end

endmodule

@@ bench/testbench.sv @@
// stimulus and verdict for the multicast group membership table
module testbench
    import mgmt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH      = 64;
    localparam int unsigned POOL_SIZE  = 12;
    // request code with no meaning: the block must leave its state alone
    localparam logic [1:0]  REQ_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // interface_req[2:0], group_address[34:3], rec_mode[37:35]
    logic [1:0]  s_axis_tuser;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // forward_mask[7:0]
    logic [2:0]  m_axis_tuser;   // general_query[0], group_query[1], table_full[2]

    int mismatches;
    int outstanding;

    // both sides run without gaps while this is set
    logic quiet_phase = 1'b0;

    // stimulus-side view of the query timer, used only to line up phase ends
    logic [QI_W-1:0] ticks_since_query = '0;
    logic [QI_W-1:0] query_every       = QUERY_INTERVAL_RST;

    // small set of groups so records hit each other and packets find members
    logic [GROUP_W-1:0] group_pool [POOL_SIZE];

    multicast_group_membership_table #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    membership_table_watch #(
        .TABLE_DEPTH(DEPTH)
    ) watch (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    // result side: stalls at random, about 19 percent of the time, except in the quiet phase
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= quiet_phase || ($urandom_range(99) >= 19);
        end
    end

    // offers one request item and returns at the falling edge after its acceptance
    task automatic push_request(input logic [1:0] kind, input logic [IFACE_W-1:0] ifc,
                                input logic [GROUP_W-1:0] grp,
                                input logic [MODE_W-1:0] mode);
        // random gap before the item, with valid held low
        if (!quiet_phase && $urandom_range(99) < 19)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, mode, grp, ifc};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        // follow the query timer so each phase can end right after a general query
        if (kind == REQ_TICK)
        begin
            ticks_since_query = ticks_since_query + 1'b1;
            if (ticks_since_query == query_every)
                ticks_since_query = '0;
        end
    endtask

    initial
    begin
        int pick;
        logic [IFACE_W-1:0] ifc;
        logic [GROUP_W-1:0] grp;
        logic [MODE_W-1:0]  mode;
        logic [QI_W-1:0]    next_interval;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_RECORD;

        // pool holds the address extremes plus class-d addresses
        group_pool[0] = '0;
        group_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            group_pool[i] = {4'hE, 4'($urandom_range(15)), 24'($urandom)};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, under the reset query interval
        // lookup on an empty table
        push_request(REQ_PACKET, 3'd0, 32'h0000_0000, 3'd0);
        // field extremes on the record path
        push_request(REQ_RECORD, 3'd0, 32'h0000_0000, 3'd0);
        push_request(REQ_RECORD, 3'd7, 32'hFFFF_FFFF, 3'd7);
        // leave on a new entry, then leave on an existing one
        push_request(REQ_RECORD, 3'd7, 32'h0000_0000, LEAVE_RECORD);
        push_request(REQ_RECORD, 3'd0, 32'h0000_0000, LEAVE_RECORD);
        // lookups see members whatever their mode
        push_request(REQ_PACKET, 3'd0, 32'h0000_0000, 3'd0);
        push_request(REQ_PACKET, 3'd7, 32'hFFFF_FFFF, 3'd7);
        push_request(REQ_TICK, 3'd7, 32'hFFFF_FFFF, 3'd7);
        push_request(REQ_TICK, 3'd0, 32'h0000_0000, 3'd0);
        // meaningless request code, all ones and all zeros in the fields
        push_request(REQ_UNUSED, 3'd7, 32'hFFFF_FFFF, 3'd7);
        push_request(REQ_UNUSED, 3'd0, 32'h0000_0000, 3'd0);
        // every record mode, one interface each, same group
        for (int m = 0; m < 8; m++)
            push_request(REQ_RECORD, 3'(m), 32'hE000_0001, 3'(m));
        // mode overwrite on an existing entry
        push_request(REQ_RECORD, 3'd2, 32'hE000_0001, 3'd5);
        // all eight interfaces in the mask
        push_request(REQ_PACKET, 3'd4, 32'hE000_0001, 3'd2);

        // random phases: reset interval, then low extreme, a quiet phase, a random
        // interval and the high extreme
        for (int p = 0; p < 5; p++)
        begin
            if (p > 0)
            begin
                case (p)
                    1:       next_interval = 16'd1;
                    2:       next_interval = 16'd3;
                    3:       next_interval = 16'($urandom_range(60, 4));
                    default: next_interval = 16'hFFFF;
                endcase
                quiet_phase = (p == 2);
                // register writes only with the block drained and no item offered
                s_axis_tvalid <= 1'b0;
                while (outstanding != 0)
                    @(negedge clk);
                repeat (4) @(negedge clk);
                cfg_we    <= 1'b1;
                cfg_wdata <= next_interval;
                @(negedge clk);
                cfg_we    <= 1'b0;
                query_every = next_interval;
            end

            for (int n = 0; n < ((p == 0) ? 250 : 290); n++)
            begin
                pick = $urandom_range(99);
                ifc  = 3'($urandom_range(7));
                grp  = $urandom;
                mode = 3'($urandom_range(7));
                if (pick < 42)
                begin
                    // mostly pooled groups, some fresh ones that eat table space
                    if ($urandom_range(99) < 85)
                        grp = group_pool[$urandom_range(POOL_SIZE - 1)];
                    if ($urandom_range(99) < 20)
                        mode = LEAVE_RECORD;
                    push_request(REQ_RECORD, ifc, grp, mode);
                end
                else if (pick < 70)
                begin
                    if ($urandom_range(99) < 80)
                        grp = group_pool[$urandom_range(POOL_SIZE - 1)];
                    push_request(REQ_PACKET, ifc, grp, mode);
                end
                else if (pick < 95)
                    push_request(REQ_TICK, ifc, grp, mode);
                else
                    push_request(REQ_UNUSED, ifc, grp, mode);
            end

            // end on a general query so the next interval starts from a zero count
            if (p < 4)
                while (ticks_since_query != 0)
                    push_request(REQ_TICK, 3'($urandom_range(7)), $urandom,
                                 3'($urandom_range(7)));
        end

        s_axis_tvalid <= 1'b0;
        quiet_phase = 1'b0;

        // wait for every result, then keep watching for anything stray
        while (outstanding != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
